// File: hw/rtl/mcr_pkg.sv
// ============================================================================
// mcr_pkg
// Shared constants and types for the midpoint circle rasterizer.
// ============================================================================
`default_nettype none

package mcr_pkg;

    localparam int COORD_BITS = 10;
    localparam int CIN_W      = 10;
    localparam int RAD_W      = 9;
    localparam int PIX_W      = 12;
    localparam int DEC_W      = 13;
    localparam int DIM_W      = 11;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_PIX    = 8;
    localparam int PIX_CNT_W  = $clog2(NUM_PIX);

    localparam logic [PIX_CNT_W-1:0] LAST_PIX = PIX_CNT_W'(NUM_PIX - 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COLOR  = CFG_IDX_W'(2);

    localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = DIM_W'(400);
    localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = DIM_W'(400);
    localparam logic [COLOR_W-1:0] PIXEL_COLOR_RST  = COLOR_W'(24'hFAFAFA);

    localparam logic [DEC_W-1:0] DEC_INIT     = DEC_W'(3);
    localparam logic [DEC_W-1:0] DEC_INC_NEG  = DEC_W'(6);
    localparam logic [DEC_W-1:0] DEC_INC_DIAG = DEC_W'(10);

    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] ox;
        logic [COORD_BITS-1:0] oy;
        logic                  done;
    } step_t;

    typedef struct packed {
        logic can_load;
        logic busy;
        logic last_pix;
    } emit_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/mcr_item_if.sv
// ============================================================================
// mcr_item_if
// Request channel carrying start/advance items into the rasterizer.
// ============================================================================
`default_nettype none

interface mcr_item_if;
    logic                          valid;
    logic                          ready;
    logic                          start_req;
    logic [mcr_pkg::CIN_W-1:0]     center_x;
    logic [mcr_pkg::CIN_W-1:0]     center_y;
    logic [mcr_pkg::RAD_W-1:0]     radius;

    modport source (output valid, start_req, center_x, center_y, radius, input ready);
    modport sink   (input valid, start_req, center_x, center_y, radius, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mcr_pixel_if.sv
// ============================================================================
// mcr_pixel_if
// Result channel carrying rasterized pixels, one per transfer.
// ============================================================================
`default_nettype none

interface mcr_pixel_if;
    logic                               valid;
    logic                               ready;
    logic signed [mcr_pkg::PIX_W-1:0]   pixel_x;
    logic signed [mcr_pkg::PIX_W-1:0]   pixel_y;
    logic [mcr_pkg::COLOR_W-1:0]        color;
    logic                               on_image;
    logic                               last_of_step;
    logic                               circle_done;

    modport source (output valid, pixel_x, pixel_y, color, on_image, last_of_step,
                    circle_done, input ready);
    modport sink   (input valid, pixel_x, pixel_y, color, on_image, last_of_step,
                    circle_done, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mcr_cfg_if.sv
// ============================================================================
// mcr_cfg_if
// Register write channel: index plus write data.
// ============================================================================
`default_nettype none

interface mcr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mcr_pkg::CFG_IDX_W-1:0]     index;
    logic [mcr_pkg::COLOR_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/midpoint_circle_rasterizer.sv
// ============================================================================
// midpoint_circle_rasterizer
// Midpoint circle rasterizer: start/advance requests in, octant pixels out.
// ============================================================================
// An accepted request is loaded into the emitter's step register, and with the result
// channel ready its first pixel then goes into the output register.
// The emitter sends one pixel per cycle while the result channel is ready; the
// next request is taken in the cycle the eighth pixel enters the output register.
// Advance requests with no active circle are accepted and give no pixels.
// Reset clears the circle state and loads the register defaults; no warm-up.
`default_nettype none

module midpoint_circle_rasterizer (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mcr_item_if.sink     item,
    mcr_pixel_if.source  pixel,
    mcr_cfg_if.sink      cfg
);

    logic [mcr_pkg::DIM_W-1:0]   image_width_reg;
    logic [mcr_pkg::DIM_W-1:0]   image_height_reg;
    logic [mcr_pkg::COLOR_W-1:0] pixel_color_reg;

    mcr_pkg::step_t        step;
    mcr_pkg::emit_status_t status;
    logic                  step_emit;
    logic                  item_fire;
    logic                  cfg_fire;

    assign cfg.ready  = 1'b1;
    assign cfg_fire   = cfg.valid && cfg.ready;
    assign item.ready = status.can_load;
    assign item_fire  = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= mcr_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= mcr_pkg::IMAGE_HEIGHT_RST;
            pixel_color_reg  <= mcr_pkg::PIXEL_COLOR_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg.index)
                mcr_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= mcr_pkg::DIM_W'(cfg.data);
                mcr_pkg::REG_IMAGE_HEIGHT: image_height_reg <= mcr_pkg::DIM_W'(cfg.data);
                mcr_pkg::REG_PIXEL_COLOR:  pixel_color_reg  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    mcr_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (item_fire),
        .start_req (item.start_req),
        .center_x  (item.center_x),
        .center_y  (item.center_y),
        .radius    (item.radius),
        .step      (step),
        .emit      (step_emit)
    );

    mcr_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (item_fire && step_emit),
        .step_in      (step),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .pixel_color  (pixel_color_reg),
        .pixel        (pixel),
        .status       (status)
    );

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.circle_done |-> pixel.last_of_step)
        else $error("circle_done without last_of_step");

    a_take_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && status.busy |-> status.last_pix)
        else $error("request taken while a step is still being sent");

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.start_req |=> status.busy)
        else $error("start request did not load the emitter");

endmodule

`default_nettype wire

// File: hw/rtl/mcr_step.sv
// ============================================================================
// mcr_step
// Circle state and midpoint decision update, one step per accepted request that starts or continues a circle.
// ============================================================================
`default_nettype none

module mcr_step (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          start_req,
    input  wire logic [mcr_pkg::CIN_W-1:0]     center_x,
    input  wire logic [mcr_pkg::CIN_W-1:0]     center_y,
    input  wire logic [mcr_pkg::RAD_W-1:0]     radius,
    output mcr_pkg::step_t                     step,
    output logic                               emit
);

    logic [mcr_pkg::COORD_BITS-1:0] step_x_reg, step_x_next;
    logic [mcr_pkg::COORD_BITS-1:0] step_y_reg, step_y_next;
    logic [mcr_pkg::DEC_W-1:0]      decision_reg, decision_next;
    logic [mcr_pkg::COORD_BITS-1:0] held_cx_reg;
    logic [mcr_pkg::COORD_BITS-1:0] held_cy_reg;
    logic                           active_reg, active_next;

    logic [mcr_pkg::COORD_BITS-1:0] cur_cx, cur_cy, cur_x, cur_y;
    logic [mcr_pkg::DEC_W-1:0]      cur_d, x_ext, y_ext;
    logic                           cur_active;
    logic                           y_dec;
    logic [mcr_pkg::COORD_BITS:0]   x_inc, y_new;
    logic                           done;

    always_comb
    begin
        cur_cx     = start_req ? mcr_pkg::COORD_BITS'(center_x) : held_cx_reg;
        cur_cy     = start_req ? mcr_pkg::COORD_BITS'(center_y) : held_cy_reg;
        cur_x      = start_req ? '0 : step_x_reg;
        cur_y      = start_req ? mcr_pkg::COORD_BITS'(radius) : step_y_reg;
        cur_d      = start_req
                   ? mcr_pkg::DEC_INIT - (mcr_pkg::DEC_W'(radius) << 1)
                   : decision_reg;
        cur_active = start_req | active_reg;

        x_ext = mcr_pkg::DEC_W'(cur_x);
        y_ext = mcr_pkg::DEC_W'(cur_y);
        y_dec = ~cur_d[mcr_pkg::DEC_W-1];

        if (y_dec)
        begin
            decision_next = cur_d + ((x_ext - y_ext) << 2) + mcr_pkg::DEC_INC_DIAG;
        end
        else
        begin
            decision_next = cur_d + (x_ext << 2) + mcr_pkg::DEC_INC_NEG;
        end

        // y may step below zero; that always finishes the circle
        x_inc = {1'b0, cur_x} + (mcr_pkg::COORD_BITS+1)'(1);
        y_new = {1'b0, cur_y} - (mcr_pkg::COORD_BITS+1)'(y_dec);
        done  = (y_dec && (cur_y == '0)) || (x_inc > y_new);

        step_x_next = done ? '0 : x_inc[mcr_pkg::COORD_BITS-1:0];
        step_y_next = done ? '0 : y_new[mcr_pkg::COORD_BITS-1:0];
        active_next = ~done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            decision_reg <= '0;
            held_cx_reg  <= '0;
            held_cy_reg  <= '0;
            active_reg   <= 1'b0;
        end
        else if (accept && cur_active)
        begin
            held_cx_reg  <= cur_cx;
            held_cy_reg  <= cur_cy;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
            active_reg   <= active_next;
        end
    end

    assign step.cx   = cur_cx;
    assign step.cy   = cur_cy;
    assign step.ox   = cur_x;
    assign step.oy   = cur_y;
    assign step.done = done;
    assign emit      = cur_active;

endmodule

`default_nettype wire

// File: hw/rtl/mcr_emit.sv
// ============================================================================
// mcr_emit
// Holds one step and sends its eight octant mirror pixels, one per cycle while the
// receiver is ready, through a registered output.
// ============================================================================
`default_nettype none

module mcr_emit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire mcr_pkg::step_t                step_in,
    input  wire logic [mcr_pkg::DIM_W-1:0]     image_width,
    input  wire logic [mcr_pkg::DIM_W-1:0]     image_height,
    input  wire logic [mcr_pkg::COLOR_W-1:0]   pixel_color,
    mcr_pixel_if.source                        pixel,
    output mcr_pkg::emit_status_t              status
);

    mcr_pkg::step_t                  step_reg;
    logic                            busy_reg, busy_next;
    logic [mcr_pkg::PIX_CNT_W-1:0]   cnt_reg, cnt_next;

    logic                            out_valid_reg, out_valid_next;
    logic [mcr_pkg::PIX_W-1:0]       pixel_x_reg, pixel_x_next;
    logic [mcr_pkg::PIX_W-1:0]       pixel_y_reg, pixel_y_next;
    logic [mcr_pkg::COLOR_W-1:0]     color_reg;
    logic                            on_image_reg, on_image_next;
    logic                            last_reg, last_next;
    logic                            done_reg, done_next;

    logic                            advance;
    logic                            at_last;
    logic [mcr_pkg::COORD_BITS-1:0]  col_off, row_off;
    logic                            col_neg, row_neg;
    logic [mcr_pkg::PIX_W-1:0]       cx_ext, cy_ext, col_ext, row_ext;

    assign advance = busy_reg && (!out_valid_reg || pixel.ready);
    assign at_last = (cnt_reg == mcr_pkg::LAST_PIX);

    always_comb
    begin
        col_neg = cnt_reg[2];
        unique case (cnt_reg)
            3'd0, 3'd3, 3'd4, 3'd6: row_neg = 1'b0;
            3'd1, 3'd2, 3'd5, 3'd7: row_neg = 1'b1;
            default:                row_neg = 1'b0;
        endcase

        // odd pairs of the octant order swap the roles of x and y
        col_off = cnt_reg[1] ? step_reg.oy : step_reg.ox;
        row_off = cnt_reg[1] ? step_reg.ox : step_reg.oy;

        cx_ext  = mcr_pkg::PIX_W'(step_reg.cx);
        cy_ext  = mcr_pkg::PIX_W'(step_reg.cy);
        col_ext = mcr_pkg::PIX_W'(col_off);
        row_ext = mcr_pkg::PIX_W'(row_off);

        pixel_x_next  = col_neg ? cx_ext - col_ext : cx_ext + col_ext;
        pixel_y_next  = row_neg ? cy_ext - row_ext : cy_ext + row_ext;
        on_image_next = !pixel_x_next[mcr_pkg::PIX_W-1]
                     && !pixel_y_next[mcr_pkg::PIX_W-1]
                     && (mcr_pkg::DIM_W'(pixel_x_next) < image_width)
                     && (mcr_pkg::DIM_W'(pixel_y_next) < image_height);
        last_next     = at_last;
        done_next     = at_last && step_reg.done;

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (advance)
        begin
            busy_next = !at_last;
            cnt_next  = cnt_reg + mcr_pkg::PIX_CNT_W'(1);
        end
        else
        begin
            busy_next = busy_reg;
            cnt_next  = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            step_reg <= step_in;
        end
        if (advance)
        begin
            pixel_x_reg  <= pixel_x_next;
            pixel_y_reg  <= pixel_y_next;
            color_reg    <= pixel_color;
            on_image_reg <= on_image_next;
            last_reg     <= last_next;
            done_reg     <= done_next;
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.pixel_x      = $signed(pixel_x_reg);
    assign pixel.pixel_y      = $signed(pixel_y_reg);
    assign pixel.color        = color_reg;
    assign pixel.on_image     = on_image_reg;
    assign pixel.last_of_step = last_reg;
    assign pixel.circle_done  = done_reg;

    assign status.can_load = !busy_reg || (advance && at_last);
    assign status.busy     = busy_reg;
    assign status.last_pix = advance && at_last;

endmodule

`default_nettype wire

// File: tb/sv/midpoint_circle_rasterizer_tb.sv
// ============================================================================
// midpoint_circle_rasterizer_tb
// Self-checking bench for the midpoint circle rasterizer. Start and advance
// requests go in on the item channel. A scoreboard steps its own copy of the
// circle state and queues the eight octant pixels expected per step. Every
// pixel taken from the result channel is compared field by field. Register
// settings change between phases while the block is drained. Both channels
// are throttled at random, and the receiver holds off once for a long stretch.
// ============================================================================
`default_nettype none

module midpoint_circle_rasterizer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 57;
    localparam int HOLD_AT      = 20;

    localparam logic [mcr_pkg::CFG_IDX_W-1:0] REG_UNUSED = mcr_pkg::CFG_IDX_W'(3);

    typedef struct packed {
        logic signed [mcr_pkg::PIX_W-1:0] px;
        logic signed [mcr_pkg::PIX_W-1:0] py;
        logic [mcr_pkg::COLOR_W-1:0]      color;
        logic                             on;
        logic                             last;
        logic                             done;
    } pixel_t;

    class circle_scoreboard;
        pixel_t                           expected_q[$];
        int                               errors;
        logic [mcr_pkg::DIM_W-1:0]        width_reg;
        logic [mcr_pkg::DIM_W-1:0]        height_reg;
        logic [mcr_pkg::COLOR_W-1:0]      color_reg;
        logic [mcr_pkg::COORD_BITS-1:0]   sx;
        logic [mcr_pkg::COORD_BITS-1:0]   sy;
        logic signed [mcr_pkg::DEC_W-1:0] dec;
        logic [mcr_pkg::COORD_BITS-1:0]   hcx;
        logic [mcr_pkg::COORD_BITS-1:0]   hcy;
        bit                               active;

        function new();
            errors     = 0;
            width_reg  = mcr_pkg::IMAGE_WIDTH_RST;
            height_reg = mcr_pkg::IMAGE_HEIGHT_RST;
            color_reg  = mcr_pkg::PIXEL_COLOR_RST;
            sx         = '0;
            sy         = '0;
            dec        = '0;
            hcx        = '0;
            hcy        = '0;
            active     = 1'b0;
        endfunction

        function void set_reg(logic [mcr_pkg::CFG_IDX_W-1:0] idx,
                              logic [mcr_pkg::COLOR_W-1:0] data);
            case (idx)
                mcr_pkg::REG_IMAGE_WIDTH:  width_reg  = data[mcr_pkg::DIM_W-1:0];
                mcr_pkg::REG_IMAGE_HEIGHT: height_reg = data[mcr_pkg::DIM_W-1:0];
                mcr_pkg::REG_PIXEL_COLOR:  color_reg  = data;
                default: ;
            endcase
        endfunction

        function void push_pixel(int px, int py, bit last, bit done);
            pixel_t                           p;
            logic signed [mcr_pkg::PIX_W-1:0] wx;
            logic signed [mcr_pkg::PIX_W-1:0] wy;
            wx      = px[mcr_pkg::PIX_W-1:0];
            wy      = py[mcr_pkg::PIX_W-1:0];
            p.px    = wx;
            p.py    = wy;
            p.color = color_reg;
            p.on    = (wx >= 0) && (wy >= 0) && (int'(wx) < int'(width_reg))
                      && (int'(wy) < int'(height_reg));
            p.last  = last;
            p.done  = done;
            expected_q.push_back(p);
        endfunction

        // returns 1 when the request produces a step of pixels
        function bit note_item(bit start, logic [mcr_pkg::CIN_W-1:0] cx,
                               logic [mcr_pkg::CIN_W-1:0] cy,
                               logic [mcr_pkg::RAD_W-1:0] r);
            int ccx;
            int ccy;
            int ox;
            int oy;
            int x;
            int y;
            int d;
            bit done;
            if (start)
            begin
                hcx    = cx;
                hcy    = cy;
                sx     = '0;
                sy     = mcr_pkg::COORD_BITS'(r);
                dec    = mcr_pkg::DEC_W'(3 - 2 * int'(r));
                active = 1'b1;
            end
            if (!active)
                return 1'b0;
            ccx = hcx;
            ccy = hcy;
            ox  = sx;
            oy  = sy;
            x   = ox;
            y   = oy;
            d   = dec;
            if (d < 0)
                d = d + 4 * x + 6;
            else
            begin
                d = d + 4 * (x - y) + 10;
                y = y - 1;
            end
            x    = x + 1;
            done = (x > y);
            push_pixel(ccx + ox, ccy + oy, 1'b0, 1'b0);
            push_pixel(ccx + ox, ccy - oy, 1'b0, 1'b0);
            push_pixel(ccx + oy, ccy - ox, 1'b0, 1'b0);
            push_pixel(ccx + oy, ccy + ox, 1'b0, 1'b0);
            push_pixel(ccx - ox, ccy + oy, 1'b0, 1'b0);
            push_pixel(ccx - ox, ccy - oy, 1'b0, 1'b0);
            push_pixel(ccx - oy, ccy + ox, 1'b0, 1'b0);
            push_pixel(ccx - oy, ccy - ox, 1'b1, done);
            dec = d[mcr_pkg::DEC_W-1:0];
            if (done)
            begin
                active = 1'b0;
                sx     = '0;
                sy     = '0;
            end
            else
            begin
                sx = x[mcr_pkg::COORD_BITS-1:0];
                sy = y[mcr_pkg::COORD_BITS-1:0];
            end
            return 1'b1;
        endfunction

        function void field_check(string name, logic [mcr_pkg::COLOR_W-1:0] e,
                                  logic [mcr_pkg::COLOR_W-1:0] a);
            if (e !== a)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_pixel(pixel_t act);
            pixel_t exp;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none actual %h", $time, act);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            field_check("pixel_x", exp.px, act.px);
            field_check("pixel_y", exp.py, act.py);
            field_check("color", exp.color, act.color);
            field_check("on_image", exp.on, act.on);
            field_check("last_of_step", exp.last, act.last);
            field_check("circle_done", exp.done, act.done);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mcr_item_if  item_if();
    mcr_pixel_if pix_if();
    mcr_cfg_if   cfg_if();

    midpoint_circle_rasterizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .pixel (pix_if),
        .cfg   (cfg_if)
    );

    circle_scoreboard sb = new();

    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   rx_hold;
    int   cycle_count;
    event hold_go;

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold)
            pix_if.ready <= 1'b0;
        else
            pix_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_if.valid && pix_if.ready)
            sb.check_pixel({pix_if.pixel_x, pix_if.pixel_y, pix_if.color, pix_if.on_image,
                            pix_if.last_of_step, pix_if.circle_done});
    end

    // leaves valid high so back-to-back requests need no extra edge
    task automatic send_item(bit start, logic [mcr_pkg::CIN_W-1:0] cx,
                             logic [mcr_pkg::CIN_W-1:0] cy,
                             logic [mcr_pkg::RAD_W-1:0] r, output bit stepped);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.start_req <= start;
        item_if.center_x  <= cx;
        item_if.center_y  <= cy;
        item_if.radius    <= r;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        stepped = sb.note_item(start, cx, cy, r);
    endtask

    task automatic send_rand_advance();
        bit stepped;
        send_item(1'b0, mcr_pkg::CIN_W'($urandom), mcr_pkg::CIN_W'($urandom),
                  mcr_pkg::RAD_W'($urandom), stepped);
    endtask

    task automatic finish_circle(int max_steps);
        for (int n = 0; n < max_steps && sb.active; n++)
            send_rand_advance();
    endtask

    task automatic write_reg(logic [mcr_pkg::CFG_IDX_W-1:0] idx,
                             logic [mcr_pkg::COLOR_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        sb.set_reg(idx, data);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        bit stepped;
        send_rand_advance();
        send_item(1'b1, 10'd0, 10'd0, 9'd0, stepped);
        send_rand_advance();
        send_item(1'b1, 10'd1023, 10'd1023, 9'd511, stepped);
        send_rand_advance();
        send_rand_advance();
        send_item(1'b1, 10'd0, 10'd0, 9'd511, stepped);
        send_rand_advance();
        send_rand_advance();
        send_item(1'b1, 10'd200, 10'd200, 9'd3, stepped);
        finish_circle(8);
        send_item(1'b1, 10'd1023, 10'd0, 9'd1, stepped);
        finish_circle(8);
        send_item(1'b1, 10'd5, 10'd1023, 9'd2, stepped);
        finish_circle(8);
        send_item(1'b1, 10'd399, 10'd399, 9'd256, stepped);
        send_rand_advance();
        send_rand_advance();
    endtask

    task automatic run_random(int count, bit with_hold);
        int                        counted;
        bit                        start;
        bit                        stepped;
        int                        sel;
        logic [mcr_pkg::RAD_W-1:0] r;
        counted = 0;
        while (counted < count)
        begin
            if (with_hold && counted == HOLD_AT)
                -> hold_go;
            if (sb.active)
                start = ($urandom_range(99) < 5);
            else
                start = ($urandom_range(99) < 85);
            sel = $urandom_range(99);
            if (sel < 60)
                r = mcr_pkg::RAD_W'($urandom_range(12));
            else if (sel < 90)
                r = mcr_pkg::RAD_W'($urandom_range(64, 13));
            else
                r = mcr_pkg::RAD_W'($urandom);
            send_item(start, mcr_pkg::CIN_W'($urandom), mcr_pkg::CIN_W'($urandom), r,
                      stepped);
            if (stepped)
                counted++;
        end
    endtask

    task automatic configure(int phase);
        case (phase)
            0:
            begin
                write_reg(mcr_pkg::REG_IMAGE_WIDTH, mcr_pkg::COLOR_W'(1024));
                write_reg(mcr_pkg::REG_IMAGE_HEIGHT, mcr_pkg::COLOR_W'(1024));
                write_reg(mcr_pkg::REG_PIXEL_COLOR, 24'h000000);
            end
            1:
            begin
                write_reg(mcr_pkg::REG_IMAGE_WIDTH, mcr_pkg::COLOR_W'(0));
                write_reg(mcr_pkg::REG_IMAGE_HEIGHT, mcr_pkg::COLOR_W'(0));
                write_reg(mcr_pkg::REG_PIXEL_COLOR, 24'hFFFFFF);
                write_reg(REG_UNUSED, mcr_pkg::COLOR_W'($urandom));
            end
            2:
            begin
                write_reg(mcr_pkg::REG_IMAGE_WIDTH, mcr_pkg::COLOR_W'(1));
                write_reg(mcr_pkg::REG_IMAGE_HEIGHT, mcr_pkg::COLOR_W'(1));
                write_reg(mcr_pkg::REG_PIXEL_COLOR, mcr_pkg::COLOR_W'($urandom));
            end
            4:
            begin
                write_reg(mcr_pkg::REG_IMAGE_WIDTH, mcr_pkg::COLOR_W'($urandom));
                write_reg(mcr_pkg::REG_IMAGE_HEIGHT, mcr_pkg::COLOR_W'($urandom));
                write_reg(mcr_pkg::REG_PIXEL_COLOR, mcr_pkg::COLOR_W'($urandom));
                write_reg(REG_UNUSED, mcr_pkg::COLOR_W'($urandom));
            end
            default:
            begin
                write_reg(mcr_pkg::REG_IMAGE_WIDTH,
                          mcr_pkg::COLOR_W'($urandom_range(1024, 1)));
                write_reg(mcr_pkg::REG_IMAGE_HEIGHT,
                          mcr_pkg::COLOR_W'($urandom_range(1024, 1)));
                write_reg(mcr_pkg::REG_PIXEL_COLOR, mcr_pkg::COLOR_W'($urandom));
            end
        endcase
    endtask

    initial
    begin
        rst_n             = 1'b0;
        item_if.valid     = 1'b0;
        item_if.start_req = 1'b0;
        item_if.center_x  = '0;
        item_if.center_y  = '0;
        item_if.radius    = '0;
        pix_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        rx_hold           = 1'b0;
        cycle_count       = 0;
        tx_idle_pct       = 8;
        rx_idle_pct       = 69;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            configure(phase);
            case (phase / 2)
                0:
                begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 69;
                end
                1:
                begin
                    tx_idle_pct = 69;
                    rx_idle_pct = 8;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            run_random(PHASE_ITEMS, phase == 1);
            drain();
        end

        if (sb.pending() != 0)
        begin
            $display("%0t: pixels still pending, expected 0 actual %0d", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
